/* src/fpc_pkg.sv */
`timescale 1ns / 1ps

package fpc_pkg;

	// command codes carried in the low bits of the input request
	typedef enum logic [2:0] {
		CMD_SET_PTR = 3'd0,
		CMD_WRITE   = 3'd1,
		CMD_READ    = 3'd2,
		CMD_TACHO   = 3'd3,
		CMD_WINDOW  = 3'd4
	} cmd_t;

	// register map seen through the pointer
	localparam logic [7:0] REG_STATUS  = 8'd0;
	localparam logic [7:0] REG_SPEED   = 8'd1;
	localparam logic [7:0] REG_MIN     = 8'd2;
	localparam logic [7:0] REG_RPS     = 8'd3;
	localparam logic [7:0] REG_RPM_LO  = 8'd4;
	localparam logic [7:0] REG_RPM_HI  = 8'd5;
	localparam logic [7:0] LAST_REG    = REG_RPM_HI;

	// calibration and scaling constants
	localparam logic [15:0] RPM_LIMIT   = 16'd200;
	localparam logic [7:0]  RAMP_STEP   = 8'd5;
	localparam logic [7:0]  FULL_SCALE  = 8'd255;
	localparam int          RPM_PER_RPS = 60;

	// strobes from the register stage to the tacho counter
	typedef struct packed {
		logic tick;
		logic close;
	} tacho_ctl_t;

endpackage

/* src/fpc_tacho.sv */
`timescale 1ns / 1ps

// tacho edge counter that keeps running quotients of the count divided by
// the window length, so rps and rpm are ready when the window closes
module fpc_tacho #(
	parameter int WINDOW_SECONDS = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  fpc_pkg::tacho_ctl_t ctl,
	output logic [7:0]        rps,
	output logic [15:0]       rpm
);

	localparam int RemW    = $clog2(WINDOW_SECONDS + 1);
	localparam int RpmMax  = 65535 * fpc_pkg::RPM_PER_RPS / WINDOW_SECONDS;
	localparam int RpmW    = $clog2(RpmMax + 1);

	typedef logic [RemW:0]   rem_sum_t;
	typedef logic [RpmW-1:0] rpm_acc_t;

	localparam rem_sum_t WinLen     = rem_sum_t'(WINDOW_SECONDS);
	localparam rem_sum_t RpsRemStep = rem_sum_t'(1 % WINDOW_SECONDS);
	localparam rem_sum_t RpmRemStep = rem_sum_t'(fpc_pkg::RPM_PER_RPS % WINDOW_SECONDS);
	localparam logic [15:0] RpsQStep = 16'(1 / WINDOW_SECONDS);
	localparam rpm_acc_t RpmQStep   = rpm_acc_t'(fpc_pkg::RPM_PER_RPS / WINDOW_SECONDS);

	logic [15:0]     cnt_q;
	logic [15:0]     rps_quo_q;
	logic [RemW-1:0] rps_rem_q;
	rpm_acc_t        rpm_quo_q;
	logic [RemW-1:0] rpm_rem_q;

	rem_sum_t rps_sum;
	rem_sum_t rpm_sum;
	logic     rps_carry;
	logic     rpm_carry;
	logic     count_en;

	// remainder steps with a single compare against the window length
	always_comb begin
		rps_sum   = rem_sum_t'(rps_rem_q) + RpsRemStep;
		rpm_sum   = rem_sum_t'(rpm_rem_q) + RpmRemStep;
		rps_carry = (rps_sum >= WinLen);
		rpm_carry = (rpm_sum >= WinLen);
		count_en  = ctl.tick && (cnt_q != 16'hFFFF);
	end

	// counters, cleared when the window closes, frozen once the count saturates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			rps_quo_q <= '0;
			rps_rem_q <= '0;
			rpm_quo_q <= '0;
			rpm_rem_q <= '0;
		end else if (ctl.close) begin
			cnt_q     <= '0;
			rps_quo_q <= '0;
			rps_rem_q <= '0;
			rpm_quo_q <= '0;
			rpm_rem_q <= '0;
		end else if (count_en) begin
			cnt_q     <= cnt_q + 16'd1;
			rps_quo_q <= rps_quo_q + RpsQStep + {15'd0, rps_carry};
			rps_rem_q <= rps_carry ? RemW'(rps_sum - WinLen) : RemW'(rps_sum);
			rpm_quo_q <= rpm_quo_q + RpmQStep + rpm_acc_t'(rpm_carry);
			rpm_rem_q <= rpm_carry ? RemW'(rpm_sum - WinLen) : RemW'(rpm_sum);
		end
	end

	// results of the current window
	assign rps = rps_quo_q[7:0];
	assign rpm = (32'(rpm_quo_q) > 32'h0000_FFFF) ? 16'hFFFF : rpm_quo_q[15:0];

endmodule

/* src/fan_pwm_register_controller.sv */
`timescale 1ns / 1ps

// fan controller with six byte registers behind a register pointer
//
// input channel s_*: one request per transfer, cmd and data in s_tdata.
//   commands: set pointer, write byte, read byte, tacho edge, window end.
// output channel m_*: exactly one result per request, in request order,
//   carrying the read byte, the duty level, the lamp and the status bit.
// each request passes the input register, then the register update logic
//   feeding the result register.
// throughput: one request per cycle unless m_tready stalls; the register
//   file, the duty mapping (one 8x8 multiply with a divide by 255 done as
//   shift and add) and the tacho quotient counters act on the input register.
// when m_tready is low the result register holds, the input register
//   still takes one more request, and s_tready drops once both are full.
// reset: pointer and registers clear, duty is 0, calibration is pending,
//   and the next window end starts the calibration ramp.
// rpm and rps are derived from the tacho count over WINDOW_SECONDS.
module fan_pwm_register_controller #(
	parameter int WINDOW_SECONDS = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [2:0] cmd, [10:3] data, rest zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // [7:0] read_data, [15:8] pwm_duty,
	                               // [16] led_on, [17] calibrating, rest zero
);

	// input register
	logic       valid_s1;
	logic [2:0] cmd_s1;
	logic [7:0] data_s1;

	// register state
	logic [7:0]  ptr_q;
	logic        status_q;
	logic [7:0]  speed_q;
	logic [7:0]  min_q;
	logic [7:0]  duty_q;
	logic [7:0]  rps_q;
	logic [15:0] rpm_q;
	logic        pend_q;
	logic        run_q;
	logic        lamp_q;

	// result register
	logic        out_valid_q;
	logic [7:0]  rd_q;

	logic [7:0]  ptr_d;
	logic        status_d;
	logic [7:0]  speed_d;
	logic [7:0]  min_d;
	logic [7:0]  duty_d;
	logic [7:0]  rps_d;
	logic [15:0] rpm_d;
	logic        pend_d;
	logic        run_d;
	logic        lamp_d;
	logic [7:0]  rd_d;
	logic [7:0]  ptr_next;

	logic        adv;
	logic        fire;
	fpc_pkg::tacho_ctl_t tctl;
	logic [7:0]  win_rps;
	logic [15:0] win_rpm;

	// duty = speed * (255 - min) / 255 + min, zero speed stops the fan
	function automatic logic [7:0] duty_map(input logic [7:0] spd, input logic [7:0] mn);
		logic [15:0] prod;
		logic [16:0] acc;
		begin
			prod = 16'(spd) * 16'(fpc_pkg::FULL_SCALE - mn);
			acc  = 17'(prod) + 17'(prod[15:8]) + 17'd1;
			if (spd == 8'd0) begin
				duty_map = 8'd0;
			end else begin
				duty_map = acc[15:8] + mn;
			end
		end
	endfunction

	// handshake
	assign adv      = !out_valid_q || m_tready;
	assign fire     = valid_s1 && adv;
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1  <= s_tdata[2:0];
			data_s1 <= s_tdata[10:3];
		end
	end

	// tacho strobes
	always_comb begin
		tctl.tick  = fire && (cmd_s1 == fpc_pkg::CMD_TACHO);
		tctl.close = fire && (cmd_s1 == fpc_pkg::CMD_WINDOW);
	end

	fpc_tacho #(
		.WINDOW_SECONDS(WINDOW_SECONDS)
	) u_tacho (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (tctl),
		.rps   (win_rps),
		.rpm   (win_rpm)
	);

	// pointer step with wrap after the last register or out of range
	assign ptr_next = (ptr_q < fpc_pkg::LAST_REG) ? ptr_q + 8'd1 : 8'd0;

	// register update for one request
	always_comb begin
		ptr_d    = ptr_q;
		status_d = status_q;
		speed_d  = speed_q;
		min_d    = min_q;
		duty_d   = duty_q;
		rps_d    = rps_q;
		rpm_d    = rpm_q;
		pend_d   = pend_q;
		run_d    = run_q;
		lamp_d   = lamp_q;
		rd_d     = 8'd0;
		case (fpc_pkg::cmd_t'(cmd_s1))
			fpc_pkg::CMD_SET_PTR: begin
				ptr_d = data_s1;
			end
			fpc_pkg::CMD_WRITE: begin
				ptr_d = ptr_next;
				if (!pend_q && !run_q) begin
					unique case (ptr_q)
						fpc_pkg::REG_STATUS: begin
							status_d = data_s1[0];
							if (data_s1[0]) begin
								pend_d = 1'b1;
							end
						end
						fpc_pkg::REG_SPEED: begin
							speed_d = data_s1;
							duty_d  = duty_map(data_s1, min_q);
						end
						fpc_pkg::REG_MIN: begin
							min_d  = data_s1;
							duty_d = duty_map(speed_q, data_s1);
						end
						default: begin
						end
					endcase
				end
			end
			fpc_pkg::CMD_READ: begin
				ptr_d = ptr_next;
				unique case (ptr_q)
					fpc_pkg::REG_STATUS: rd_d = {7'd0, status_q};
					fpc_pkg::REG_SPEED:  rd_d = speed_q;
					fpc_pkg::REG_MIN:    rd_d = min_q;
					fpc_pkg::REG_RPS:    rd_d = rps_q;
					fpc_pkg::REG_RPM_LO: rd_d = rpm_q[7:0];
					fpc_pkg::REG_RPM_HI: rd_d = rpm_q[15:8];
					default:             rd_d = 8'd0;
				endcase
			end
			fpc_pkg::CMD_WINDOW: begin
				rps_d = win_rps;
				rpm_d = win_rpm;
				// calibration ramp
				if (pend_q) begin
					if (!run_q) begin
						duty_d   = 8'd0;
						status_d = 1'b1;
						lamp_d   = 1'b1;
						run_d    = 1'b1;
					end else begin
						pend_d = 1'b0;
					end
				end else if (run_q) begin
					if (win_rpm > fpc_pkg::RPM_LIMIT) begin
						min_d    = duty_q + fpc_pkg::RAMP_STEP;
						run_d    = 1'b0;
						status_d = 1'b0;
						duty_d   = 8'd0;
						lamp_d   = 1'b0;
					end else begin
						duty_d   = duty_q + fpc_pkg::RAMP_STEP;
						status_d = 1'b1;
						lamp_d   = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q       <= '0;
			status_q    <= 1'b0;
			speed_q     <= '0;
			min_q       <= '0;
			duty_q      <= '0;
			rps_q       <= '0;
			rpm_q       <= '0;
			pend_q      <= 1'b1;
			run_q       <= 1'b0;
			lamp_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				ptr_q    <= ptr_d;
				status_q <= status_d;
				speed_q  <= speed_d;
				min_q    <= min_d;
				duty_q   <= duty_d;
				rps_q    <= rps_d;
				rpm_q    <= rpm_d;
				pend_q   <= pend_d;
				run_q    <= run_d;
				lamp_q   <= lamp_d;
			end
			if (adv) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (fire) begin
			rd_q <= rd_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, status_q, lamp_q, duty_q, rd_q};

	// lamp is lit only during the ramp
	a_lamp_run: assert property (@(posedge clk) disable iff (!arst_n) lamp_q |-> run_q)
		else $error("lamp lit outside calibration ramp");

	// status bit stays set while the ramp runs
	a_run_status: assert property (@(posedge clk) disable iff (!arst_n) run_q |-> status_q)
		else $error("status bit clear during calibration ramp");

	// pointer lands in range after any register access
	a_ptr_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (cmd_s1 == fpc_pkg::CMD_WRITE || cmd_s1 == fpc_pkg::CMD_READ))
		|=> (ptr_q <= fpc_pkg::LAST_REG))
		else $error("pointer out of range after access");

	// a waiting input request is held while the result side stalls
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(cmd_s1) && $stable(data_s1)))
		else $error("input register lost a stalled request");

endmodule
